@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) else $error(msg);
// Assertion on the usual clk and arst_n of the enclosing module.
`define ASSERT_STD(lbl, prop, msg) \
	`ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define ASSERT_CLK(lbl, clock, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif

`endif

@@ rtl/core/dtna_pkg.sv @@
// ----------------------------------------------------------------------------
// dtna_pkg
// Types and constants shared by the diamond tile neighbour addresser.
// ----------------------------------------------------------------------------
package dtna_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BOARD_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_BOARD_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_WRAP_ENABLE  = 2'd2;

	localparam int CFG_DATA_W = 9;

	// Reset values of the configuration registers.
	localparam logic [8:0] RST_BOARD_WIDTH  = 9'd16;
	localparam logic [8:0] RST_BOARD_HEIGHT = 9'd16;
	localparam logic       RST_WRAP_ENABLE  = 1'b0;

	// Input beat.
	typedef struct packed {
		logic [7:0] cell_col;
		logic [7:0] cell_row;
	} cell_in_t;

	// Output beat.
	typedef struct packed {
		logic [7:0] up_col;
		logic [7:0] up_row;
		logic [7:0] right_col;
		logic [7:0] right_row;
		logic [7:0] down_col;
		logic [7:0] down_row;
		logic [7:0] left_col;
		logic [7:0] left_row;
		logic       off_board;
	} neigh_out_t;

	// Board geometry after clamping to the maximum size.
	typedef struct packed {
		logic [8:0] width;
		logic [8:0] height;
		logic       wrap;
	} geom_t;

	// Cell position flags and candidate coordinates, handed to the select stage.
	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] col_p1;
		logic [7:0] col_m1;
		logic [7:0] row_p1;
		logic [7:0] row_m1;
		logic [7:0] w_m1;
		logic [7:0] h_m1;
		logic       off;
		logic       even;
		logic       top;
		logic       bottom;
		logic       first;
		logic       last;
		logic       wrap;
		logic       w_even;
	} prep_t;

endpackage

@@ rtl/core/dtna_prep.sv @@
// ----------------------------------------------------------------------------
// dtna_prep
// Second pipeline stage: classifies the cell against the board edges and
// forms the neighbouring row and column indexes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtna_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  dtna_pkg::geom_t   geom,
	input  logic              up_valid,
	input  dtna_pkg::cell_in_t up_data,
	output logic              up_ready,
	output logic              valid_s2,
	output dtna_pkg::prep_t   data_s2,
	input  logic              dn_ready
);

	dtna_pkg::prep_t prep;
	logic [8:0]      col_x;
	logic [8:0]      row_x;
	logic [8:0]      w_m1;
	logic [8:0]      h_m1;

	// Edge flags and neighbour candidates, all wrapped to eight bits.
	always_comb begin
		col_x = {1'b0, up_data.cell_col};
		row_x = {1'b0, up_data.cell_row};
		w_m1  = geom.width - 9'd1;
		h_m1  = geom.height - 9'd1;

		prep.col    = up_data.cell_col;
		prep.row    = up_data.cell_row;
		prep.col_p1 = up_data.cell_col + 8'd1;
		prep.col_m1 = up_data.cell_col - 8'd1;
		prep.row_p1 = up_data.cell_row + 8'd1;
		prep.row_m1 = up_data.cell_row - 8'd1;
		prep.w_m1   = w_m1[7:0];
		prep.h_m1   = h_m1[7:0];
		prep.off    = (col_x >= geom.width) || (row_x >= geom.height);
		prep.even   = ~up_data.cell_col[0];
		prep.top    = (up_data.cell_row == 8'd0);
		prep.bottom = (row_x == h_m1);
		prep.first  = (up_data.cell_col == 8'd0);
		prep.last   = (col_x == w_m1);
		prep.wrap   = geom.wrap;
		prep.w_even = ~geom.width[0];
	end

	assign up_ready = !valid_s2 || dn_ready;

	// Stage register; the payload holds while the next stage stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s2 <= prep;
		end
	end

	`ASSERT_STD(a_prep_hold, valid_s2 && !dn_ready |=> valid_s2 && $stable(data_s2), "prep stage lost a stalled beat")
	`ASSERT_STD(a_prep_take, up_valid && up_ready |=> valid_s2, "prep stage dropped an accepted beat")

endmodule

@@ rtl/core/dtna_select.sv @@
// ----------------------------------------------------------------------------
// dtna_select
// Third pipeline stage: picks each neighbour from the candidates according to
// column parity, board edges and wrap mode, and holds the output beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtna_select (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	input  dtna_pkg::prep_t      up_data,
	output logic                 up_ready,
	output logic                 valid_s3,
	output dtna_pkg::neigh_out_t data_s3,
	input  logic                 dn_ready
);

	dtna_pkg::neigh_out_t res;

	// Neighbour selection. Every neighbour starts as the cell itself.
	always_comb begin
		res.up_col    = up_data.col;
		res.up_row    = up_data.row;
		res.right_col = up_data.col;
		res.right_row = up_data.row;
		res.down_col  = up_data.col;
		res.down_row  = up_data.row;
		res.left_col  = up_data.col;
		res.left_row  = up_data.row;
		res.off_board = up_data.off;

		if (!up_data.off) begin
			// Plain offsets inside the board.
			if (up_data.even) begin
				if (!up_data.top && !up_data.last) begin
					res.up_col = up_data.col_p1;
					res.up_row = up_data.row_m1;
				end
				if (!up_data.last) begin
					res.right_col = up_data.col_p1;
				end
				if (!up_data.first) begin
					res.down_col = up_data.col_m1;
				end
				if (!up_data.top && !up_data.first) begin
					res.left_col = up_data.col_m1;
					res.left_row = up_data.row_m1;
				end
			end else begin
				if (!up_data.last) begin
					res.up_col = up_data.col_p1;
				end
				if (!up_data.bottom && !up_data.last) begin
					res.right_col = up_data.col_p1;
					res.right_row = up_data.row_p1;
				end
				if (!up_data.bottom) begin
					res.down_col = up_data.col_m1;
					res.down_row = up_data.row_p1;
				end
				res.left_col = up_data.col_m1;
			end

			if (up_data.wrap) begin
				// Even cells of the top row reach the bottom row.
				if (up_data.even && up_data.top) begin
					if (!up_data.first) begin
						res.left_col = up_data.col_m1;
						res.left_row = up_data.h_m1;
					end
					if (!up_data.last) begin
						res.up_col = up_data.col_p1;
						res.up_row = up_data.h_m1;
					end
				end
				// Odd cells of the bottom row reach the top row.
				if (!up_data.even && up_data.bottom) begin
					res.right_col = up_data.col_p1;
					res.right_row = 8'd0;
					res.down_col  = up_data.col_m1;
					res.down_row  = 8'd0;
				end
				// Side columns join only on a board of even width.
				if (up_data.w_even) begin
					if (up_data.first) begin
						res.down_col = up_data.w_m1;
						res.down_row = up_data.row;
						res.left_col = up_data.w_m1;
						res.left_row = up_data.top ? up_data.h_m1 : up_data.row_m1;
					end
					if (up_data.last) begin
						res.right_col = 8'd0;
						res.right_row = up_data.bottom ? 8'd0 : up_data.row_p1;
						res.up_col    = 8'd0;
						res.up_row    = up_data.row;
					end
				end
			end
		end
	end

	assign up_ready = !valid_s3 || dn_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s3 <= res;
		end
	end

	`ASSERT_STD(a_off_self, valid_s3 && data_s3.off_board |-> data_s3.up_col == data_s3.left_col && data_s3.right_row == data_s3.down_row, "off-board beat has differing neighbours")
	`ASSERT_STD(a_sel_hold, valid_s3 && !dn_ready |=> valid_s3 && $stable(data_s3), "output beat changed while stalled")

endmodule

@@ rtl/core/diamond_tile_neighbour_addresser.sv @@
// Pipeline: an accepted input beat passes the input register, the prep stage register and the output register.
// Throughput: one beat per cycle while out_ready is high; each of the three register
// stages passes a beat on whenever the stage after it is empty or is being drained.
// Reset: arst_n clears all stage valid bits and loads board width 16,
// height 16 and wrap off. No clearing pass is needed.
// ----------------------------------------------------------------------------
// diamond_tile_neighbour_addresser
// Gives the up, right, down and left neighbours of a cell on a diamond board.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module diamond_tile_neighbour_addresser #(
	parameter int MAX_BOARD_SIZE = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [8:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dtna_pkg::cell_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dtna_pkg::neigh_out_t out_data
);

	localparam logic [12:0] MAX_SIZE = 13'(MAX_BOARD_SIZE);

	logic [8:0]         board_width_q;
	logic [8:0]         board_height_q;
	logic               wrap_enable_q;
	dtna_pkg::geom_t    geom;
	logic               valid_s1;
	dtna_pkg::cell_in_t cell_s1;
	logic               prep_ready;
	logic               valid_s2;
	dtna_pkg::prep_t    data_s2;
	logic               sel_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_width_q  <= dtna_pkg::RST_BOARD_WIDTH;
			board_height_q <= dtna_pkg::RST_BOARD_HEIGHT;
			wrap_enable_q  <= dtna_pkg::RST_WRAP_ENABLE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dtna_pkg::CFG_BOARD_WIDTH:  board_width_q  <= cfg_data;
				dtna_pkg::CFG_BOARD_HEIGHT: board_height_q <= cfg_data;
				dtna_pkg::CFG_WRAP_ENABLE:  wrap_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sizes above the maximum board size are taken as the maximum.
	always_comb begin
		geom.width  = ({4'd0, board_width_q} > MAX_SIZE) ? MAX_SIZE[8:0] : board_width_q;
		geom.height = ({4'd0, board_height_q} > MAX_SIZE) ? MAX_SIZE[8:0] : board_height_q;
		geom.wrap   = wrap_enable_q;
	end

	// Input register.
	assign in_ready = !valid_s1 || prep_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cell_s1 <= in_data;
		end
	end

	dtna_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.up_valid (valid_s1),
		.up_data  (cell_s1),
		.up_ready (prep_ready),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.dn_ready (sel_ready)
	);

	dtna_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s2),
		.up_data  (data_s2),
		.up_ready (sel_ready),
		.valid_s3 (out_valid),
		.data_s3  (out_data),
		.dn_ready (out_ready)
	);

	`ASSERT_STD(a_in_take, in_valid && in_ready |=> valid_s1, "input beat not captured")
	`ASSERT_STD(a_s1_hold, valid_s1 && !prep_ready |=> valid_s1 && $stable(cell_s1), "input stage lost a stalled beat")

endmodule

@@ dv/tb_diamond_tile_neighbour_addresser.sv @@
// ----------------------------------------------------------------------------
// tb_diamond_tile_neighbour_addresser
// Self-checking bench for the diamond tile neighbour addresser. A short table
// of directed queries and board settings is walked first. Random board
// geometries and random queries follow under several patterns of sender
// idling and receiver stalling. Every output beat is checked field by field
// against a hand-written answer or a local neighbour calculation.
// ----------------------------------------------------------------------------
module tb_diamond_tile_neighbour_addresser;

	localparam int MAX_BOARD   = 256;
	localparam int CYCLE_LIMIT = 200000;
	// Index with no register behind it; writes to it must change nothing.
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef enum logic {ROW_CONFIG, ROW_CELL} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [8:0]           width;
		logic [8:0]           height;
		logic                 wrap;
		dtna_pkg::cell_in_t   query;
		bit                   known;
		dtna_pkg::neigh_out_t want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [1:0]           cfg_index = '0;
	logic [8:0]           cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	dtna_pkg::cell_in_t   in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	dtna_pkg::neigh_out_t out_data;

	// Side information that travels with each input beat.
	bit                   in_known = 1'b0;
	dtna_pkg::neigh_out_t in_want = '0;

	// Local copy of the board registers.
	logic [8:0] board_w = dtna_pkg::RST_BOARD_WIDTH;
	logic [8:0] board_h = dtna_pkg::RST_BOARD_HEIGHT;
	logic       board_wrap = dtna_pkg::RST_WRAP_ENABLE;

	dtna_pkg::neigh_out_t pending_neighbours[$];
	dtna_pkg::neigh_out_t oldest;
	stim_row_t            directed[$];
	int                   errors = 0;
	int                   cycles = 0;
	int                   send_idle = 0;
	int                   recv_stall = 0;

	diamond_tile_neighbour_addresser #(
		.MAX_BOARD_SIZE(MAX_BOARD)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Free-running clock with a period of ten units.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Neighbours of one cell on the board currently held in the local copy.
	function automatic dtna_pkg::neigh_out_t neighbours_of(dtna_pkg::cell_in_t c);
		int i, j, w, h;
		int uc, ur, rc, rr, dc, dr, lc, lr;
		bit even, top, bottom, first, last;
		dtna_pkg::neigh_out_t n;
		i = c.cell_col;
		j = c.cell_row;
		w = (board_w > MAX_BOARD) ? MAX_BOARD : board_w;
		h = (board_h > MAX_BOARD) ? MAX_BOARD : board_h;
		uc = i; ur = j; rc = i; rr = j; dc = i; dr = j; lc = i; lr = j;
		n.off_board = 1'b0;
		if (i >= w || j >= h) begin
			n.off_board = 1'b1;
		end else begin
			even   = (i % 2) == 0;
			top    = j == 0;
			bottom = j == h - 1;
			first  = i == 0;
			last   = i == w - 1;
			// Plain offsets; a neighbour over an edge stays on the cell.
			if (even) begin
				if (!top && !last) begin uc = i + 1; ur = j - 1; end
				if (!last) begin rc = i + 1; rr = j; end
				if (!first) begin dc = i - 1; dr = j; end
				if (!top && !first) begin lc = i - 1; lr = j - 1; end
			end else begin
				if (!last) begin uc = i + 1; ur = j; end
				if (!bottom && !last) begin rc = i + 1; rr = j + 1; end
				if (!bottom) begin dc = i - 1; dr = j + 1; end
				lc = i - 1; lr = j;
			end
			// Wrapping across the top and bottom rows, then the side columns.
			if (board_wrap) begin
				if (even && top) begin
					if (!first) begin lc = i - 1; lr = h - 1; end
					if (!last) begin uc = i + 1; ur = h - 1; end
				end
				if (!even && bottom) begin
					rc = i + 1; rr = 0;
					dc = i - 1; dr = 0;
				end
				if ((w % 2) == 0) begin
					if (first) begin
						dc = w - 1; dr = j;
						lc = w - 1;
						lr = top ? h - 1 : j - 1;
					end
					if (last) begin
						rc = 0;
						rr = bottom ? 0 : j + 1;
						uc = 0; ur = j;
					end
				end
			end
		end
		n.up_col    = uc[7:0];
		n.up_row    = ur[7:0];
		n.right_col = rc[7:0];
		n.right_row = rr[7:0];
		n.down_col  = dc[7:0];
		n.down_row  = dr[7:0];
		n.left_col  = lc[7:0];
		n.left_row  = lr[7:0];
		return n;
	endfunction

	function automatic dtna_pkg::cell_in_t make_cell(int c, int r);
		dtna_pkg::cell_in_t x;
		x.cell_col = c[7:0];
		x.cell_row = r[7:0];
		return x;
	endfunction

	function automatic dtna_pkg::neigh_out_t spell(int uc, int ur, int rc, int rr,
		int dc, int dr, int lc, int lr, bit off);
		dtna_pkg::neigh_out_t n;
		n.up_col    = uc[7:0];
		n.up_row    = ur[7:0];
		n.right_col = rc[7:0];
		n.right_row = rr[7:0];
		n.down_col  = dc[7:0];
		n.down_row  = dr[7:0];
		n.left_col  = lc[7:0];
		n.left_row  = lr[7:0];
		n.off_board = off;
		return n;
	endfunction

	// Off-board answer: every neighbour is the queried cell itself.
	function automatic dtna_pkg::neigh_out_t stay(int c, int r);
		return spell(c, r, c, r, c, r, c, r, 1'b1);
	endfunction

	function automatic void add_board(int w, int h, bit wrap);
		stim_row_t row;
		row = '{kind: ROW_CONFIG, width: w[8:0], height: h[8:0], wrap: wrap,
			query: '0, known: 1'b0, want: '0};
		directed.push_back(row);
	endfunction

	function automatic void add_query(int c, int r);
		stim_row_t row;
		row = '{kind: ROW_CELL, width: '0, height: '0, wrap: 1'b0,
			query: make_cell(c, r), known: 1'b0, want: '0};
		directed.push_back(row);
	endfunction

	function automatic void add_known(int c, int r, dtna_pkg::neigh_out_t want);
		stim_row_t row;
		row = '{kind: ROW_CELL, width: '0, height: '0, wrap: 1'b0,
			query: make_cell(c, r), known: 1'b1, want: want};
		directed.push_back(row);
	endfunction

	function automatic void build_directed();
		// Reset board: 16 by 16, no wrap.
		add_known(0, 0, spell(0, 0, 1, 0, 0, 0, 0, 0, 1'b0));
		add_known(4, 4, spell(5, 3, 5, 4, 3, 4, 3, 3, 1'b0));
		add_known(16, 0, stay(16, 0));
		add_known(255, 255, stay(255, 255));
		add_query(15, 15);
		add_query(7, 3);
		// Even width with wrap: corners, top and bottom rows, side columns.
		add_board(16, 16, 1'b1);
		add_query(0, 0);
		add_query(15, 15);
		add_query(15, 0);
		add_query(0, 15);
		add_query(6, 0);
		add_query(7, 15);
		add_query(15, 7);
		// Odd width: the side columns do not wrap.
		add_board(15, 9, 1'b1);
		add_query(14, 8);
		add_query(0, 0);
		add_query(13, 8);
		add_known(15, 0, stay(15, 0));
		// Zero width leaves no cell on the board.
		add_board(0, 16, 1'b0);
		add_known(0, 0, stay(0, 0));
		// Largest board, then sizes above the maximum.
		add_board(256, 256, 1'b1);
		add_query(255, 255);
		add_query(0, 0);
		add_query(255, 0);
		add_board(511, 300, 1'b0);
		add_query(255, 255);
		add_query(128, 200);
		// Single cell board.
		add_board(1, 1, 1'b1);
		add_query(0, 0);
		add_known(0, 1, stay(0, 1));
	endfunction

	function automatic logic [8:0] pick_size();
		case ($urandom_range(0, 9))
			0: begin
				return 9'd256;
			end
			1: begin
				return $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
			end
			2: begin
				return 9'd1;
			end
			default: begin
				return 9'($urandom_range(1, 24));
			end
		endcase
	endfunction

	// Mostly cells on the board with a bias towards its edges, otherwise any cell.
	function automatic dtna_pkg::cell_in_t pick_cell();
		int w, h, c, r;
		w = (board_w > MAX_BOARD) ? MAX_BOARD : board_w;
		h = (board_h > MAX_BOARD) ? MAX_BOARD : board_h;
		if (w > 0 && h > 0 && $urandom_range(0, 4) != 0) begin
			case ($urandom_range(0, 3))
				0: c = 0;
				1: c = w - 1;
				default: c = $urandom_range(0, w - 1);
			endcase
			case ($urandom_range(0, 3))
				0: r = 0;
				1: r = h - 1;
				default: r = $urandom_range(0, h - 1);
			endcase
		end else begin
			c = $urandom_range(0, 255);
			r = $urandom_range(0, 255);
		end
		return make_cell(c, r);
	endfunction

	// Drop the input and wait until every expected beat has come out.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_neighbours.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Load a new board geometry while the block is idle.
	task automatic set_board(logic [8:0] w, logic [8:0] h, logic wrap);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= dtna_pkg::CFG_BOARD_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= dtna_pkg::CFG_BOARD_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= dtna_pkg::CFG_WRAP_ENABLE;
		cfg_data  <= {8'($urandom_range(0, 255)), wrap};
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= 9'($urandom_range(0, 511));
		@(posedge clk);
		cfg_write  <= 1'b0;
		board_w    = w;
		board_h    = h;
		board_wrap = wrap;
	endtask

	// Offer one query beat, with a random gap before it, and wait for acceptance.
	task automatic send_cell(dtna_pkg::cell_in_t c, bit known, dtna_pkg::neigh_out_t want);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		in_known <= known;
		in_want  <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// Record accepted queries and check each output beat against the oldest one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_neighbours.push_back(in_known ? in_want : neighbours_of(in_data));
			end
			if (out_valid && out_ready) begin
				if (pending_neighbours.size() == 0) begin
					$display("%0t: output beat with nothing expected, got %h",
						$time, out_data);
					errors++;
				end else begin
					oldest = pending_neighbours.pop_front();
					check_field("up_col", oldest.up_col, out_data.up_col);
					check_field("up_row", oldest.up_row, out_data.up_row);
					check_field("right_col", oldest.right_col, out_data.right_col);
					check_field("right_row", oldest.right_row, out_data.right_row);
					check_field("down_col", oldest.down_col, out_data.down_col);
					check_field("down_row", oldest.down_row, out_data.down_row);
					check_field("left_col", oldest.left_col, out_data.left_col);
					check_field("left_row", oldest.left_row, out_data.left_row);
					check_field("off_board", oldest.off_board, out_data.off_board);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("diamond_tile_neighbour_addresser regression: fail");
			$finish;
		end
	end

	initial begin
		build_directed();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling.
		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CONFIG) begin
				set_board(directed[k].width, directed[k].height, directed[k].wrap);
			end else begin
				send_cell(directed[k].query, directed[k].known, directed[k].want);
			end
		end

		// Random geometries and queries under each idling pattern.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 55; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 55; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			for (int s = 0; s < 5; s++) begin
				set_board(pick_size(), pick_size(), 1'($urandom_range(0, 1)));
				repeat (50) send_cell(pick_cell(), 1'b0, '0);
			end
		end

		settle();
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("diamond_tile_neighbour_addresser regression: pass");
		end else begin
			$display("diamond_tile_neighbour_addresser regression: fail");
		end
		$finish;
	end

endmodule
